// ----- rtl/cwm_pkg.sv -----
// ---------------------------------------------------------------------------
// cwm_pkg
// Shared constants, types and control structs of the windowed utilization
// monitor.
// ---------------------------------------------------------------------------
package cwm_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int TICK_BITS  = 48;
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int NUM_WIN    = 3;
  localparam int NUM_CTR    = 4;
  localparam int PCT_W      = 14;
  localparam int SUM_W      = TICK_BITS + 2;
  localparam int DIFF_W     = TICK_BITS + 3;
  localparam int REM_W      = DIFF_W + 1;
  localparam int ROW_W      = NUM_CTR * TICK_BITS;
  localparam int IN_W       = 224;
  localparam int OUT_W      = 168;
  localparam int TW_W       = TIME_W + 2;

  localparam logic [PCT_W-1:0] FULL_SCALE = 14'd10000;

  // configuration register indexes
  localparam logic [1:0] CFG_SHORT = 2'd0;
  localparam logic [1:0] CFG_MID   = 2'd1;
  localparam logic [1:0] CFG_LONG  = 2'd2;

  localparam logic [WIN_W-1:0] SHORT_RST = 16'd60;
  localparam logic [WIN_W-1:0] MID_RST   = 16'd300;
  localparam logic [WIN_W-1:0] LONG_RST  = 16'd900;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_STORE,
    ST_SCAN,
    ST_LOAD,
    ST_SETUP,
    ST_PREP,
    ST_CHECK,
    ST_DIVW,
    ST_WRB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              capture;
    logic              clr_wr;
    logic              find;
    logic              scan;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              store;
    logic              ld_rd;
    logic [1:0]        sel;
    logic              setup;
    logic              prep;
    logic              div_start;
    logic              res_wr;
    logic [1:0]        c;
    logic [1:0]        w;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_done;
    logic out_valid;
  } status_t;

endpackage

// ----- rtl/cwm_div.sv -----
// ---------------------------------------------------------------------------
// cwm_div
// Serial scaled divider: floor(10000 * a / b) for a < b, one half step
// (double-and-reduce or add-and-reduce) per cycle.
// ---------------------------------------------------------------------------
module cwm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cwm_pkg::DIFF_W-1:0] a,
  input  logic [cwm_pkg::DIFF_W-1:0] b,
  output logic                      done,
  output logic [cwm_pkg::PCT_W-1:0] q
);

  logic                       busy;
  logic [4:0]                 step;
  logic [cwm_pkg::REM_W-1:0]  r, r_next, r_tmp;
  logic [cwm_pkg::PCT_W:0]    qa, qa_next, q_tmp;
  logic [3:0]                 bit_sel;

  assign bit_sel = 4'(cwm_pkg::PCT_W - 1) - step[4:1];

  always_comb begin
    if (!step[0]) begin
      r_tmp = {r[cwm_pkg::REM_W-2:0], 1'b0};
      q_tmp = {qa[cwm_pkg::PCT_W-1:0], 1'b0};
    end else begin
      r_tmp = cwm_pkg::FULL_SCALE[bit_sel] ? r + {1'b0, a} : r;
      q_tmp = qa;
    end
    if (step[0] && !cwm_pkg::FULL_SCALE[bit_sel]) begin
      r_next  = r_tmp;
      qa_next = q_tmp;
    end else if (r_tmp >= {1'b0, b}) begin
      r_next  = r_tmp - {1'b0, b};
      qa_next = q_tmp + 1'b1;
    end else begin
      r_next  = r_tmp;
      qa_next = q_tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd27) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r  <= '0;
      qa <= '0;
    end else if (busy) begin
      r  <= r_next;
      qa <= qa_next;
    end
  end

  assign q = (qa > {1'b0, cwm_pkg::FULL_SCALE}) ? cwm_pkg::FULL_SCALE : qa[cwm_pkg::PCT_W-1:0];

endmodule

// ----- rtl/cwm_ctrl.sv -----
// ---------------------------------------------------------------------------
// cwm_ctrl
// Sequencer: table clear after reset, free-slot pass, store, baseline pass,
// row loads and the twelve share computations.
// ---------------------------------------------------------------------------
module cwm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cwm_pkg::status_t st,
  output cwm_pkg::cmd_t    cmd
);

  cwm_pkg::state_t            state, state_next;
  logic [cwm_pkg::ADDR_W:0]   cnt, cnt_next;
  logic [1:0]                 c, c_next, w, w_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwm_pkg::ST_CLEAR;
      cnt   <= '0;
      c     <= '0;
      w     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      c     <= c_next;
      w     <= w_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    c_next     = c;
    w_next     = w;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.addr   = cnt[cwm_pkg::ADDR_W-1:0];
    cmd.sel    = cnt[1:0];
    cmd.c      = c;
    cmd.w      = w;
    unique case (state)
      cwm_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (&cnt[cwm_pkg::ADDR_W-1:0]) begin
          cnt_next   = '0;
          state_next = cwm_pkg::ST_IDLE;
        end
      end
      cwm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = cwm_pkg::ST_FIND;
        end
      end
      cwm_pkg::ST_FIND: begin
        cmd.find  = 1'b1;
        cmd.rd_en = !cnt[cwm_pkg::ADDR_W];
        cnt_next  = cnt + 1'b1;
        // the extra count step, with no read, drains the registered read
        if (cnt[cwm_pkg::ADDR_W]) begin
          cnt_next   = '0;
          state_next = cwm_pkg::ST_STORE;
        end
      end
      cwm_pkg::ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = cwm_pkg::ST_SCAN;
      end
      cwm_pkg::ST_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.rd_en = !cnt[cwm_pkg::ADDR_W];
        cnt_next  = cnt + 1'b1;
        if (cnt[cwm_pkg::ADDR_W]) begin
          cnt_next   = '0;
          state_next = cwm_pkg::ST_LOAD;
        end
      end
      cwm_pkg::ST_LOAD: begin
        cmd.ld_rd = !cnt[2];
        cnt_next  = cnt + 1'b1;
        if (cnt[2]) begin
          cnt_next   = '0;
          c_next     = '0;
          w_next     = '0;
          state_next = cwm_pkg::ST_SETUP;
        end
      end
      cwm_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = cwm_pkg::ST_PREP;
      end
      cwm_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = cwm_pkg::ST_CHECK;
      end
      cwm_pkg::ST_CHECK: begin
        if (st.skip) begin
          state_next = cwm_pkg::ST_WRB;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = cwm_pkg::ST_DIVW;
        end
      end
      cwm_pkg::ST_DIVW: begin
        if (st.div_done) state_next = cwm_pkg::ST_WRB;
      end
      cwm_pkg::ST_WRB: begin
        cmd.res_wr = 1'b1;
        state_next = cwm_pkg::ST_SETUP;
        if (w == 2'(cwm_pkg::NUM_WIN - 1)) begin
          w_next = '0;
          if (c == 2'(cwm_pkg::NUM_CTR - 1)) state_next = cwm_pkg::ST_DONE;
          else c_next = c + 2'd1;
        end else begin
          w_next = w + 2'd1;
        end
      end
      cwm_pkg::ST_DONE: begin
        if (!st.out_valid) begin
          cmd.out_load = 1'b1;
          state_next   = cwm_pkg::ST_IDLE;
        end
      end
      default: state_next = cwm_pkg::ST_IDLE;
    endcase
  end

  a_accept_find: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == cwm_pkg::ST_FIND))
    else $error("accepted word did not start the free-slot pass");

  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.skip)
    else $error("divider started on a special-case share");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_valid)
    else $error("result register overwritten while still pending");

endmodule

// ----- rtl/cwm_dpath.sv -----
// ---------------------------------------------------------------------------
// cwm_dpath
// Slot table memories, window registers, pass trackers, share setup and the
// result and output registers.
// ---------------------------------------------------------------------------
module cwm_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [cwm_pkg::WIN_W-1:0]     cfg_wdata,
  input  logic [cwm_pkg::IN_W-1:0]      in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cwm_pkg::OUT_W-1:0]     out_data,
  input  cwm_pkg::cmd_t                 cmd,
  output cwm_pkg::status_t              st
);

  localparam int AW = cwm_pkg::ADDR_W;
  localparam int TB = cwm_pkg::TICK_BITS;

  logic [cwm_pkg::WIN_W-1:0]  win [cwm_pkg::NUM_WIN];
  logic [cwm_pkg::TIME_W-1:0] now;
  logic [cwm_pkg::ROW_W-1:0]  in_row;

  logic [cwm_pkg::TIME_W-1:0] times_mem [cwm_pkg::SLOT_COUNT];
  logic [cwm_pkg::ROW_W-1:0]  row_mem   [cwm_pkg::SLOT_COUNT];

  logic [cwm_pkg::TIME_W-1:0] t_q;
  logic [AW-1:0]              addr_q;
  logic                       v_q;

  logic                       found, cur_ok;
  logic [AW-1:0]              st_idx, cur_idx;
  logic                       have [cwm_pkg::NUM_WIN];
  logic [cwm_pkg::TIME_W-1:0] base [cwm_pkg::NUM_WIN];
  logic [AW-1:0]              bidx [cwm_pkg::NUM_WIN];

  logic signed [cwm_pkg::TW_W-1:0] lo [cwm_pkg::NUM_WIN];
  logic signed [cwm_pkg::TW_W-1:0] t_s;

  logic [AW-1:0]              ld_addr;
  logic [cwm_pkg::ROW_W-1:0]  row_q;
  logic                       ld_v_q;
  logic [1:0]                 sel_q;
  logic                       row_ok;
  logic [TB-1:0]              rows [4][cwm_pkg::NUM_CTR];
  logic [cwm_pkg::SUM_W-1:0]  rsum [4];
  logic [cwm_pkg::SUM_W-1:0]  row_sum;
  logic [1:0]                 bsel;

  logic signed [cwm_pkg::DIFF_W-1:0] num, den;
  logic                              zero;
  logic [cwm_pkg::DIFF_W-1:0]        a, b, a_next, b_next;
  logic                              skip;
  logic [cwm_pkg::PCT_W-1:0]         sres;
  logic                              div_done;
  logic [cwm_pkg::PCT_W-1:0]         div_q;

  logic [cwm_pkg::PCT_W-1:0] res   [cwm_pkg::NUM_CTR][cwm_pkg::NUM_WIN];
  logic [cwm_pkg::PCT_W-1:0] out_q [cwm_pkg::NUM_CTR][cwm_pkg::NUM_WIN];

  function automatic logic [cwm_pkg::SUM_W-1:0] SUM_EXT(input logic [TB-1:0] v);
    return {2'b00, v};
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= cwm_pkg::SHORT_RST;
      win[1] <= cwm_pkg::MID_RST;
      win[2] <= cwm_pkg::LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwm_pkg::CFG_SHORT: win[0] <= cfg_wdata;
        cwm_pkg::CFG_MID:   win[1] <= cfg_wdata;
        cwm_pkg::CFG_LONG:  win[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input word: counters packed as {system, nice, user, idle}
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now    <= in_data[31:0];
      in_row <= {in_data[128 +: TB], in_data[80 +: TB], in_data[32 +: TB],
                 in_data[176 +: TB]};
    end
  end

  // slot time table
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) times_mem[cmd.addr] <= '0;
    else if (cmd.store && found) times_mem[st_idx] <= now;
    if (cmd.rd_en) t_q <= times_mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) v_q <= 1'b0;
    else v_q <= cmd.rd_en;
    addr_q <= cmd.addr;
  end

  always_comb begin
    t_s = $signed({2'b00, t_q});
    for (int i = 0; i < cwm_pkg::NUM_WIN; i++) begin
      lo[i] = $signed({2'b00, now}) - $signed({18'd0, win[i]});
    end
  end

  // pass trackers
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      found  <= 1'b0;
      cur_ok <= 1'b0;
      for (int i = 0; i < cwm_pkg::NUM_WIN; i++) have[i] <= 1'b0;
    end else if (v_q) begin
      if (cmd.find && !found && t_s < lo[2]) begin
        found  <= 1'b1;
        st_idx <= addr_q;
      end
      if (cmd.scan) begin
        if (t_q == now) begin
          cur_ok  <= 1'b1;
          cur_idx <= addr_q;
        end
        if (t_q != '0 && t_q < now) begin
          for (int i = 0; i < cwm_pkg::NUM_WIN; i++) begin
            // equal time keeps the later slot
            if (t_s >= lo[i] && (!have[i] || t_q <= base[i])) begin
              have[i] <= 1'b1;
              base[i] <= t_q;
              bidx[i] <= addr_q;
            end
          end
        end
      end
    end
  end

  // counter table
  always_comb begin
    if (cmd.sel == 2'd0) ld_addr = cur_idx;
    else ld_addr = bidx[cmd.sel - 2'd1];
  end

  always_ff @(posedge clk) begin
    if (cmd.store && found) row_mem[st_idx] <= in_row;
    if (cmd.ld_rd) row_q <= row_mem[ld_addr];
    sel_q <= cmd.sel;
  end

  always_ff @(posedge clk) begin
    if (rst) ld_v_q <= 1'b0;
    else ld_v_q <= cmd.ld_rd;
  end

  assign row_ok  = (sel_q == 2'd0) ? cur_ok : have[sel_q - 2'd1];
  assign row_sum = (SUM_EXT(row_q[0 +: TB]) + SUM_EXT(row_q[TB +: TB]))
                 + (SUM_EXT(row_q[2*TB +: TB]) + SUM_EXT(row_q[3*TB +: TB]));

  always_ff @(posedge clk) begin
    if (ld_v_q) begin
      for (int k = 0; k < cwm_pkg::NUM_CTR; k++) begin
        rows[sel_q][k] <= row_ok ? row_q[k*TB +: TB] : '0;
      end
      rsum[sel_q] <= row_ok ? row_sum : '0;
    end
  end

  // share setup
  assign bsel = cmd.w + 2'd1;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      num  <= $signed({3'b000, rows[0][cmd.c]}) - $signed({3'b000, rows[bsel][cmd.c]});
      den  <= $signed({1'b0, rsum[0]}) - $signed({1'b0, rsum[bsel]});
      zero <= !have[cmd.w] || rows[0][cmd.c] == '0 || rows[bsel][cmd.c] == '0;
    end
  end

  always_comb begin
    a_next = num[cwm_pkg::DIFF_W-1] ? cwm_pkg::DIFF_W'(-num) : num;
    b_next = den[cwm_pkg::DIFF_W-1] ? cwm_pkg::DIFF_W'(-den) : den;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      a <= a_next;
      b <= b_next;
      if (zero || den == '0 || num == '0 ||
          (num[cwm_pkg::DIFF_W-1] != den[cwm_pkg::DIFF_W-1])) begin
        skip <= 1'b1;
        sres <= '0;
      end else if (a_next >= b_next) begin
        skip <= 1'b1;
        sres <= cwm_pkg::FULL_SCALE;
      end else begin
        skip <= 1'b0;
        sres <= '0;
      end
    end
  end

  cwm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (a),
    .b     (b),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_wr) res[cmd.c][cmd.w] <= skip ? sres : div_q;
    if (cmd.out_load) out_q <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  for (genvar gc = 0; gc < cwm_pkg::NUM_CTR; gc++) begin : g_c
    for (genvar gw = 0; gw < cwm_pkg::NUM_WIN; gw++) begin : g_w
      assign out_data[(gc*cwm_pkg::NUM_WIN+gw)*cwm_pkg::PCT_W +: cwm_pkg::PCT_W] =
        out_q[gc][gw];
    end
  end

  assign st.skip      = skip;
  assign st.div_done  = div_done;
  assign st.out_valid = out_valid;

endmodule

// ----- rtl/windowed_cpu_utilization_monitor.sv -----
// ---------------------------------------------------------------------------
// windowed_cpu_utilization_monitor
// Keeps a 1024-slot table of timestamped tick samples and reports the
// idle/user/nice/system shares over three configurable windows.
// ---------------------------------------------------------------------------
// after reset the slot table is cleared, with s_axis_tready low. each
// word then runs through a free-slot search pass over the slot time memory,
// a store step, a baseline pass over the same memory, four row loads and
// twelve shares through one serial divider; a share that needs no division
// skips the divider.
// the next word is taken as soon as the previous result sits in the output
// register.
module windowed_cpu_utilization_monitor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // sample_time, user_ticks, nice_ticks, system_ticks, idle_ticks
  input  logic [cwm_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // idle_short/mid/long_pct, user_*, nice_*, system_* (14 bits each)
  output logic [cwm_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [cwm_pkg::WIN_W-1:0] cfg_wdata
);

  cwm_pkg::cmd_t    cmd;
  cwm_pkg::status_t st;

  cwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cwm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- sim/tb_windowed_cpu_utilization_monitor.sv -----
// ---------------------------------------------------------------------------
// tb_windowed_cpu_utilization_monitor
// Streams timestamped tick samples into the utilization monitor under random
// bursts and output stalls. A behavioral copy of the slot table predicts the
// twelve window shares of every accepted word, and the output stream is
// compared field by field. The window registers move through several
// settings between phases, the extremes among them.
// ---------------------------------------------------------------------------
module tb_windowed_cpu_utilization_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int NSLOT = 1024;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [cwm_pkg::IN_W-1:0]      s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [cwm_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [cwm_pkg::WIN_W-1:0]     cfg_wdata;

  windowed_cpu_utilization_monitor u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow of the slot table and window registers
  logic [31:0]  tbl_time [NSLOT];
  longint       tbl_ctr  [NSLOT][4];   // idle, user, nice, system
  logic [15:0]  win_len  [3];

  logic [cwm_pkg::IN_W-1:0]  samples_todo [$];
  logic [cwm_pkg::OUT_W-1:0] shares_due   [$];
  int unsigned cycles, fails, words_in, words_out;
  bit          took;
  int          gap_left, burst_left;
  logic [31:0] ready_pat;
  int          pat_left;

  // running counters and clock of the stimulus
  logic [31:0] now_t;
  logic [47:0] run_ctr [4];

  function automatic logic [13:0] pct(longint num, longint den);
    longint a, b;
    logic [127:0] q;
    if (den == 0 || num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    if (a >= b) return cwm_pkg::FULL_SCALE;
    q = 128'(a) * 128'd10000 / 128'(b);
    return q[13:0];
  endfunction

  function automatic logic [cwm_pkg::OUT_W-1:0] window_shares(logic [cwm_pkg::IN_W-1:0] w);
    logic [31:0] now;
    longint nowl, t, cur[4], bv[4], cs, bs;
    bit      have[3];
    longint  base[3];
    int      bidx[3];
    int      cidx;
    bit      stored;
    logic [cwm_pkg::OUT_W-1:0] r;
    now = w[31:0];
    nowl = longint'(now);
    stored = 0;
    cidx = -1;
    r = '0;
    for (int i = 0; i < NSLOT; i++)
      if (!stored && longint'(tbl_time[i]) < nowl - longint'(win_len[2])) begin
        stored = 1;
        tbl_time[i] = now;
        tbl_ctr[i][0] = longint'(w[223:176]);
        tbl_ctr[i][1] = longint'(w[79:32]);
        tbl_ctr[i][2] = longint'(w[127:80]);
        tbl_ctr[i][3] = longint'(w[175:128]);
      end
    for (int k = 0; k < 3; k++) begin
      have[k] = 0; base[k] = 0; bidx[k] = -1;
    end
    for (int i = 0; i < NSLOT; i++) begin
      t = longint'(tbl_time[i]);
      if (t != 0 && t < nowl)
        for (int k = 0; k < 3; k++)
          if (t >= nowl - longint'(win_len[k]) && (!have[k] || t < base[k])) begin
            have[k] = 1;
            base[k] = t;
          end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_time[i] == now) cidx = i;
      for (int k = 0; k < 3; k++)
        if (have[k] && longint'(tbl_time[i]) == base[k]) bidx[k] = i;
    end
    cs = 0;
    for (int c = 0; c < 4; c++) begin
      cur[c] = cidx >= 0 ? tbl_ctr[cidx][c] : 0;
      cs += cur[c];
    end
    for (int k = 0; k < 3; k++) begin
      bs = 0;
      for (int c = 0; c < 4; c++) begin
        bv[c] = bidx[k] >= 0 ? tbl_ctr[bidx[k]][c] : 0;
        bs += bv[c];
      end
      for (int c = 0; c < 4; c++)
        if (bidx[k] >= 0 && cur[c] != 0 && bv[c] != 0)
          r[(c*3+k)*cwm_pkg::PCT_W +: cwm_pkg::PCT_W] = pct(cur[c] - bv[c], cs - bs);
    end
    return r;
  endfunction

  task automatic push_sample(logic [31:0] t, logic [47:0] u, logic [47:0] n,
                             logic [47:0] s, logic [47:0] i);
    samples_todo.push_back({i, s, n, u, t});
  endtask

  // next sample of a random run: mostly steady growth, some odd cases
  task automatic push_random(int unsigned max_step);
    logic [47:0] v [4];
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) now_t = now_t - $urandom_range(0, 50);
    else now_t = now_t + $urandom_range(0, max_step);
    if (now_t == 0) now_t = 1;
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(0, 15) == 0) run_ctr[c] = 48'({$urandom, $urandom});
      else run_ctr[c] = run_ctr[c] + $urandom_range(0, 500);
      v[c] = ($urandom_range(0, 11) == 0) ? 48'd0 : run_ctr[c];
    end
    push_sample(now_t, v[0], v[1], v[2], v[3]);
  endtask

  task automatic set_window(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx != CFG_UNUSED) win_len[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    wait (samples_todo.size() == 0 && !s_axis_tvalid && shares_due.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = cwm_pkg::CFG_SHORT;
    cfg_wdata = '0;
    win_len[0] = cwm_pkg::SHORT_RST;
    win_len[1] = cwm_pkg::MID_RST;
    win_len[2] = cwm_pkg::LONG_RST;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_time[i] = '0;
      for (int c = 0; c < 4; c++) tbl_ctr[i][c] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under reset windows
    push_sample(32'd1, 48'd100, 48'd100, 48'd100, 48'd100);
    push_sample(32'd2, 48'd200, 48'd100, 48'd150, 48'd150);       // first baseline
    push_sample(32'd2, 48'd300, 48'd300, 48'd300, 48'd300);       // duplicate time
    push_sample(32'd3, 48'd0, 48'd400, 48'd400, 48'd400);         // zero counter
    push_sample(32'd4, 48'd500, 48'd500, 48'd500, 48'd500);
    push_sample(32'd5, 48'd500, 48'd500, 48'd500, 48'd500);       // zero sum delta
    push_sample(32'd6, 48'd10, 48'd900, 48'd900, 48'd900);        // negative share
    push_sample(32'd7, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd1, 48'd1);  // above full scale
    push_sample(32'd8, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_sample(32'd3, 48'd1, 48'd2, 48'd3, 48'd4);               // time goes back
    push_sample(32'd2000, 48'd7, 48'd7, 48'd7, 48'd7);            // all windows empty
    push_sample(32'd2030, 48'd9, 48'd8, 48'd7, 48'd6);
    push_sample(32'hFFFF_FFFF, 48'd1, 48'd1, 48'd1, 48'd1);
    push_sample(32'hFFFF_FFFE, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    push_sample(32'hFFFF_FFFF, 48'hFFFF_0000_FFFF, 48'hFFFF_FFFF_FFFF,
                48'h0000_FFFF_0000, 48'hFFFF_FFFF_FFFF);
    drain();

    // steady run at reset windows, fresh time base
    now_t = 32'd5000;
    for (int c = 0; c < 4; c++) run_ctr[c] = 48'd1000;
    for (int k = 0; k < 35; k++) push_random(40);
    drain();

    // tiny windows
    set_window(cwm_pkg::CFG_SHORT, 16'd1);
    set_window(cwm_pkg::CFG_MID, 16'd2);
    set_window(cwm_pkg::CFG_LONG, 16'd3);
    set_window(CFG_UNUSED, 16'hFFFF);
    now_t = 32'h0010_0000;
    for (int k = 0; k < 25; k++) push_random(3);
    drain();

    // widest windows near the top of the time range
    set_window(cwm_pkg::CFG_SHORT, 16'hFFFF);
    set_window(cwm_pkg::CFG_MID, 16'hFFFF);
    set_window(cwm_pkg::CFG_LONG, 16'hFFFF);
    now_t = 32'hFFF0_0000;
    for (int k = 0; k < 25; k++) push_random(30000);
    drain();

    // short retention so slots expire and get reused
    set_window(cwm_pkg::CFG_SHORT, 16'd5);
    set_window(cwm_pkg::CFG_MID, 16'd17);
    set_window(cwm_pkg::CFG_LONG, 16'd40);
    now_t = 32'h8000_0000;
    for (int k = 0; k < 35; k++) push_random(10);
    drain();

    repeat (50) @(posedge clk);
    $display("%0d sample words in, %0d share words out, 4 window settings", words_in,
             words_out);
    $display("covered: duplicates, back-stepping time, zero and saturated shares, expiry");
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sample side: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      took = 1;
      words_in++;
      shares_due.push_back(window_shares(s_axis_tdata));
    end
  end

  always @(negedge clk) begin
    logic nv;
    logic [cwm_pkg::IN_W-1:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!rst && (!s_axis_tvalid || took)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (samples_todo.size() != 0) begin
        nv = 1'b1;
        nd = samples_todo.pop_front();
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000)
                                                 : $urandom_range(0, 3);
        end else begin
          burst_left--;
        end
      end
    end
    took = 0;
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // share side: stall pattern reloaded from a random 32-bit word when used up
  always @(negedge clk) begin
    if (pat_left == 0) begin
      ready_pat = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      pat_left = 32;
    end
    pat_left--;
    m_axis_tready <= ready_pat[pat_left];
  end

  always @(posedge clk) begin
    logic [cwm_pkg::OUT_W-1:0] want;
    string fname;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (shares_due.size() == 0) begin
        $error("share word with nothing expected: %h", m_axis_tdata);
        fails++;
      end else begin
        want = shares_due.pop_front();
        for (int f = 0; f < 12; f++)
          if (m_axis_tdata[f*cwm_pkg::PCT_W +: cwm_pkg::PCT_W] !==
              want[f*cwm_pkg::PCT_W +: cwm_pkg::PCT_W]) begin
            case (f / 3)
              0: fname = "idle";
              1: fname = "user";
              2: fname = "nice";
              default: fname = "system";
            endcase
            case (f % 3)
              0: fname = {fname, "_short_pct"};
              1: fname = {fname, "_mid_pct"};
              default: fname = {fname, "_long_pct"};
            endcase
            $error("%s: expected %0d, got %0d", fname,
                   want[f*cwm_pkg::PCT_W +: cwm_pkg::PCT_W],
                   m_axis_tdata[f*cwm_pkg::PCT_W +: cwm_pkg::PCT_W]);
            fails++;
          end
      end
    end
  end

  initial begin
    cycles = 0; fails = 0; words_in = 0; words_out = 0;
    took = 0; gap_left = 0; burst_left = 0; pat_left = 0;
  end

endmodule
